[sv/sdtt_pkg.sv]
// types and codes shared by the sorted duration task table
`timescale 1ns / 1ps
package sdtt_pkg;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_SEARCH = 1'b1;

   localparam logic [2:0] ST_INSERTED     = 3'd0;
   localparam logic [2:0] ST_FULL         = 3'd1;
   localparam logic [2:0] ST_DUPLICATE    = 3'd2;
   localparam logic [2:0] ST_FOUND        = 3'd3;
   localparam logic [2:0] ST_NONE_SHORTER = 3'd4;
   localparam logic [2:0] ST_EMPTY        = 3'd5;

   typedef struct packed {
      logic        mode;
      logic [15:0] task_id;
      logic [15:0] task_duration;
      logic [15:0] limit;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] found_id;
      logic [4:0]  entry_count;
      logic        is_full;
      logic [19:0] duration_sum;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic capture;
      logic commit;
      logic write;
   } cmd_type;

   typedef struct packed {
      logic insert;
      logic full;
      logic dup;
   } stat_type;

endpackage

[sv/sdtt_ctrl.sv]
// controller state machine of the sorted duration task table
`timescale 1ns / 1ps
module sdtt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sdtt_pkg::stat_type stat,
   output sdtt_pkg::cmd_type  cmd
);
   import sdtt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE    = 3'b001,
      S_COMPARE = 3'b010,
      S_COMMIT  = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: state_in = S_COMMIT;
         S_COMMIT:  state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy        = (state_ff != S_IDLE);
   assign cmd.load    = start && (state_ff == S_IDLE);
   assign cmd.capture = (state_ff == S_COMPARE);
   assign cmd.commit  = (state_ff == S_COMMIT);
   assign cmd.write   = (state_ff == S_COMMIT) && stat.insert && !stat.full && !stat.dup;

   a_commit_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMMIT) |=> (state_ff == S_IDLE))
      else $error("commit not followed by idle");
   a_write_only_commit: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> (cmd.commit && !stat.full))
      else $error("write outside commit or while full");
   a_load_leads_compare: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == S_COMPARE))
      else $error("accepted request did not start compare");

endmodule

[sv/sdtt_datapath.sv]
// row of compare-and-shift cells with count, sum and response register
`timescale 1ns / 1ps
module sdtt_datapath #(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  sdtt_pkg::req_type  req_data,
   input  sdtt_pkg::cmd_type  cmd,
   output sdtt_pkg::stat_type stat,
   output logic               rsp_strobe,
   output sdtt_pkg::rsp_type  rsp_data
);
   import sdtt_pkg::*;

   localparam int CntW = ($clog2(CAPACITY + 1) > 5) ? $clog2(CAPACITY + 1) : 5;
   localparam int SumW = 16 + CntW;

   req_type                 req_ff;
   logic [15:0]             dur_ff [CAPACITY];
   logic [15:0]             id_ff  [CAPACITY];
   logic [CAPACITY-1:0]     lt_ff;
   logic [CAPACITY-1:0]     lt_in;
   logic [CAPACITY-1:0]     eq_ff;
   logic [CAPACITY-1:0]     eq_in;
   logic                    first_lt_ff;
   logic                    first_lt_in;
   logic [15:0]             last_id_ff;
   logic [CntW-1:0]         count_ff;
   logic [CntW-1:0]         count_in;
   logic [SumW-1:0]         sum_ff;
   logic [SumW-1:0]         sum_in;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;
   logic                    rsp_strobe_ff;
   logic                    at_end;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
   end

   // per-cell compare against the request
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         lt_in[i] = (CntW'(i) < count_ff) && (req_ff.task_duration < dur_ff[i]);
         eq_in[i] = (CntW'(i) < count_ff) && (req_ff.task_duration == dur_ff[i]);
      end
      first_lt_in = (count_ff != '0) && (req_ff.limit > dur_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         lt_ff       <= lt_in;
         eq_ff       <= eq_in;
         first_lt_ff <= first_lt_in;
      end
   end

   assign stat.insert = (req_ff.mode == MODE_INSERT);
   assign stat.full   = (count_ff == CntW'(CAPACITY));
   assign stat.dup    = |eq_ff;
   assign at_end      = ~|lt_ff;

   genvar g;
   for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [15:0] prev_dur;
      logic [15:0] prev_id;
      logic        shift_sel;
      logic        new_sel;
      if (g == 0) begin : g_head
         assign prev_dur  = req_ff.task_duration;
         assign prev_id   = req_ff.task_id;
         assign shift_sel = 1'b0;
      end else begin : g_body
         assign prev_dur  = dur_ff[g-1];
         assign prev_id   = id_ff[g-1];
         assign shift_sel = lt_ff[g-1];
      end
      assign new_sel = !shift_sel && (lt_ff[g] || (CntW'(g) == count_ff));
      always_ff @(posedge clock) begin
         if (cmd.write) begin
            if (shift_sel) begin
               dur_ff[g] <= prev_dur;
               id_ff[g]  <= prev_id;
            end else if (new_sel) begin
               dur_ff[g] <= req_ff.task_duration;
               id_ff[g]  <= req_ff.task_id;
            end
         end
      end
   end

   // the last entry only changes when the new task lands at the end
   always_ff @(posedge clock) begin
      if (cmd.write && at_end) begin
         last_id_ff <= req_ff.task_id;
      end
   end

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      if (cmd.write) begin
         count_in = count_ff + CntW'(1);
         sum_in   = sum_ff + SumW'(req_ff.task_duration);
      end
   end

   always_comb begin
      rsp_in.found_id = '0;
      if (stat.insert) begin
         if (stat.full) begin
            rsp_in.status = ST_FULL;
         end else if (stat.dup) begin
            rsp_in.status = ST_DUPLICATE;
         end else begin
            rsp_in.status = ST_INSERTED;
         end
      end else if (count_ff == '0) begin
         rsp_in.status = ST_EMPTY;
      end else if (first_lt_ff) begin
         rsp_in.status   = ST_FOUND;
         rsp_in.found_id = id_ff[0];
      end else begin
         rsp_in.status   = ST_NONE_SHORTER;
         rsp_in.found_id = last_id_ff;
      end
      rsp_in.entry_count  = count_in[4:0];
      rsp_in.is_full      = (count_in == CntW'(CAPACITY));
      rsp_in.duration_sum = sum_in[19:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         sum_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         rsp_strobe_ff <= cmd.commit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(CAPACITY))
      else $error("entry count above capacity");
   a_strobe_after_commit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(cmd.commit))
      else $error("result strobe without commit");
   a_write_counts: assert property (@(posedge clock) disable iff (reset)
      cmd.write |=> (count_ff == CntW'($past(count_ff) + CntW'(1))))
      else $error("insert did not advance count");

endmodule

[sv/sorted_duration_task_table_top.sv]
// top level of the sorted duration task table
`timescale 1ns / 1ps
// keeps up to CAPACITY tasks sorted by ascending duration in a row of
// compare-and-shift cells; a request is taken when start is high and busy is
// low, passes through the cell compare state and then the commit state, and
// its result appears on the cycle after the commit with rsp_strobe high for
// exactly one cycle; the next request can be taken while the result is shown;
// results cannot be held off and must be captured in that cycle
module sorted_duration_task_table_top #(
   parameter int CAPACITY = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sdtt_pkg::req_type req_data,
   output logic              rsp_strobe,
   output sdtt_pkg::rsp_type rsp_data
);
   import sdtt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   sdtt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   sdtt_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
